FILE: hw/rtl/utd_pkg.sv
// Package: shared types and constants for the UTF-8 to UTF-16 decoder.
`default_nettype none
package utd_pkg;

	// Width of the running code unit counter; the result shows its low 16 bits.
	localparam int COUNT_WIDTH = 16;

	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_VAL  = 8'hF0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_VAL  = 8'hE0;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_VAL  = 8'hC0;
	localparam logic [7:0] ASCII_MASK = 8'h80;

	localparam logic [15:0] UNIT_REPLACE = 16'hFFFF;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	typedef struct packed {
		logic        unit_valid;
		logic [7:0]  first_byte;
		logic [7:0]  second_byte;
		logic        done_res;
		logic [15:0] unit_count;
		logic        bad_input;
	} result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/utd_ifs.sv
// Interfaces: UTF-8 byte channel and UTF-16 code unit channel.
`default_nettype none
interface utd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       last_byte;

	modport source (output valid, output byte_in, output last_byte, input ready);
	modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

interface utd_unit_if;
	logic        valid;
	logic        ready;
	logic        unit_valid;
	logic [7:0]  first_byte;
	logic [7:0]  second_byte;
	logic        done_res;
	logic [15:0] unit_count;
	logic        bad_input;

	modport source (output valid, output unit_valid, output first_byte, output second_byte,
		output done_res, output unit_count, output bad_input, input ready);
	modport sink (input valid, input unit_valid, input first_byte, input second_byte,
		input done_res, input unit_count, input bad_input, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/utf8_to_utf16_decoder.sv
// Top level: UTF-8 byte stream to UTF-16 code units with end-of-string summary.
//
//   channel  | direction | payload
//   ---------+-----------+----------------------------------------------------
//   utf8     | in        | byte_in[7:0], last_byte
//   utf16    | out       | unit_valid, first_byte, second_byte, done_res,
//            |           | unit_count[15:0], bad_input
//   cfg      | in        | cfg_we, cfg_wdata (big_endian)
//
// One byte per cycle while utf8.ready is high: the byte is decoded combinationally and the state
// is registered on the accepting edge; a result goes to the output register, or to skid if stalled.
// A two-entry output buffer (output register plus skid) lets bytes keep flowing
// while one result waits; utf8.ready drops only when both entries are full.
// Reset clears decode state, counter, buffer valids and big_endian; no clearing pass.
`default_nettype none
module utf8_to_utf16_decoder (
	input  wire logic   clk,
	input  wire logic   arst_n,
	utd_byte_if.sink    utf8,
	utd_unit_if.source  utf16,
	input  wire logic   cfg_we,
	input  wire logic   cfg_wdata
);

	logic                big_endian_q;
	logic [1:0]          pend_q, pend_d;
	logic [15:0]         part_q, part_d;
	logic                obmp_q, obmp_d;
	logic                stop_q, stop_d;
	utd_pkg::count_t     cnt_q, cnt_d;

	logic                have_unit;
	logic [15:0]         unit;
	logic [15:0]         acc;
	logic [1:0]          pend_dec;
	logic                accept;
	logic                emit;
	utd_pkg::count_t     cnt_inc;
	utd_pkg::result_t    res;

	utd_pkg::result_t    out_q, skid_q;
	logic                out_v_q, skid_v_q;
	logic                out_load;

	assign accept = utf8.valid & utf8.ready;

	// Decode one byte against the current sequence state.
	always_comb begin
		pend_d    = pend_q;
		part_d    = part_q;
		obmp_d    = obmp_q;
		stop_d    = stop_q;
		have_unit = 1'b0;
		unit      = '0;
		acc       = part_q;
		pend_dec  = pend_q - 2'd1;
		if (!stop_q) begin
			if (pend_q != 2'd0) begin
				if (pend_q == 2'd2) begin
					acc = part_q | {4'd0, utf8.byte_in[5:0], 6'd0};
				end else if (pend_q == 2'd1) begin
					acc = part_q | {10'd0, utf8.byte_in[5:0]};
				end
				pend_d = pend_dec;
				part_d = acc;
				if (pend_dec == 2'd0) begin
					have_unit = 1'b1;
					unit      = obmp_q ? utd_pkg::UNIT_REPLACE : acc;
					part_d    = '0;
					obmp_d    = 1'b0;
				end
			end else if ((utf8.byte_in & utd_pkg::LEAD4_MASK) == utd_pkg::LEAD4_VAL) begin
				pend_d = 2'd3;
				obmp_d = 1'b1;
				part_d = '0;
			end else if ((utf8.byte_in & utd_pkg::LEAD3_MASK) == utd_pkg::LEAD3_VAL) begin
				pend_d = 2'd2;
				obmp_d = 1'b0;
				part_d = {utf8.byte_in[3:0], 12'd0};
			end else if ((utf8.byte_in & utd_pkg::LEAD2_MASK) == utd_pkg::LEAD2_VAL) begin
				pend_d = 2'd1;
				obmp_d = 1'b0;
				part_d = {5'd0, utf8.byte_in[4:0], 6'd0};
			end else if ((utf8.byte_in & utd_pkg::ASCII_MASK) == 8'd0) begin
				have_unit = 1'b1;
				unit      = {8'd0, utf8.byte_in};
			end else begin
				stop_d = 1'b1;
				pend_d = '0;
				part_d = '0;
				obmp_d = 1'b0;
			end
		end

		cnt_inc = cnt_q + utd_pkg::count_t'(have_unit);
		cnt_d   = cnt_inc;
		emit    = have_unit | utf8.last_byte;

		res.unit_valid  = have_unit;
		res.first_byte  = big_endian_q ? unit[15:8] : unit[7:0];
		res.second_byte = big_endian_q ? unit[7:0] : unit[15:8];
		res.done_res    = utf8.last_byte;
		res.unit_count  = 16'(cnt_inc);
		res.bad_input   = stop_d;

		// Drop all string state after the last byte.
		if (utf8.last_byte) begin
			pend_d = '0;
			part_d = '0;
			obmp_d = 1'b0;
			stop_d = 1'b0;
			cnt_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b0;
			pend_q       <= '0;
			part_q       <= '0;
			obmp_q       <= 1'b0;
			stop_q       <= 1'b0;
			cnt_q        <= '0;
		end else begin
			if (cfg_we) begin
				big_endian_q <= cfg_wdata;
			end
			if (accept) begin
				pend_q <= pend_d;
				part_q <= part_d;
				obmp_q <= obmp_d;
				stop_q <= stop_d;
				cnt_q  <= cnt_d;
			end
		end
	end

	// Output register with a skid entry behind it.
	assign out_load = !out_v_q || utf16.ready;
	assign utf8.ready = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_load) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= accept & emit;
			end
		end else if (accept && emit) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (accept && emit) begin
			skid_q <= res;
		end
	end

	assign utf16.valid       = out_v_q;
	assign utf16.unit_valid  = out_q.unit_valid;
	assign utf16.first_byte  = out_q.first_byte;
	assign utf16.second_byte = out_q.second_byte;
	assign utf16.done_res    = out_q.done_res;
	assign utf16.unit_count  = out_q.unit_count;
	assign utf16.bad_input   = out_q.bad_input;

endmodule
`default_nettype wire

FILE: hw/rtl/utd_checker.sv
// Checker: port-level properties of the decoder, bound to the top level.
`default_nettype none
module utd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        unit_valid,
	input wire logic [7:0]  first_byte,
	input wire logic [7:0]  second_byte,
	input wire logic        done_res,
	input wire logic [15:0] unit_count,
	input wire logic        bad_input
);

	// A stalled transaction holds its bytes, count and done flag.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(first_byte)
		&& $stable(second_byte) && $stable(unit_count) && $stable(done_res))
		else $error("result changed while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !unit_valid |-> first_byte == 8'd0 && second_byte == 8'd0)
		else $error("result without unit carries nonzero bytes");

	a_empty_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !unit_valid |-> done_res)
		else $error("result without unit before end of string");

	a_bad_no_unit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_input |-> !unit_valid)
		else $error("unit emitted after decode error");

	// Input stalls only behind a waiting result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

endmodule

bind utf8_to_utf16_decoder utd_checker u_utd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (utf8.ready),
	.out_valid   (utf16.valid),
	.out_ready   (utf16.ready),
	.unit_valid  (utf16.unit_valid),
	.first_byte  (utf16.first_byte),
	.second_byte (utf16.second_byte),
	.done_res    (utf16.done_res),
	.unit_count  (utf16.unit_count),
	.bad_input   (utf16.bad_input)
);
`default_nettype wire

FILE: tb/utd_result_checker.sv
// Checker: predicts UTF-16 code units from accepted UTF-8 bytes and compares the results.
`timescale 1ns / 100ps
module utd_result_checker (
	input  logic clk,
	input  logic arst_n,
	utd_byte_if  utf8,
	utd_unit_if  utf16,
	input  logic cfg_we,
	input  logic cfg_wdata,
	output int   mismatches,
	output int   outstanding,
	output int   results_seen,
	output int   units_seen
);

	// Decoder shadow state
	logic             order_high_first = 1'b0;
	logic [1:0]       conts_left       = '0;
	logic [15:0]      unit_bits        = '0;
	logic             in_astral        = 1'b0;
	logic             string_stopped   = 1'b0;
	utd_pkg::count_t  unit_total       = '0;

	utd_pkg::result_t predicted_units[$];

	task automatic clear_string();
		conts_left     = '0;
		unit_bits      = '0;
		in_astral      = 1'b0;
		string_stopped = 1'b0;
		unit_total     = '0;
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic last);
		logic             have_unit;
		logic [15:0]      unit;
		utd_pkg::result_t r;
		have_unit = 1'b0;
		unit      = '0;
		if (!string_stopped) begin
			if (conts_left != 2'd0) begin
				// Continuation bytes are taken as they come; only the low six bits count
				if (conts_left == 2'd2)
					unit_bits = unit_bits | {4'b0, b[5:0], 6'b0};
				else if (conts_left == 2'd1)
					unit_bits = unit_bits | {10'b0, b[5:0]};
				conts_left = conts_left - 2'd1;
				if (conts_left == 2'd0) begin
					have_unit = 1'b1;
					unit      = in_astral ? utd_pkg::UNIT_REPLACE : unit_bits;
					unit_bits = '0;
					in_astral = 1'b0;
				end
			end else if ((b & utd_pkg::LEAD4_MASK) == utd_pkg::LEAD4_VAL) begin
				conts_left = 2'd3;
				in_astral  = 1'b1;
				unit_bits  = '0;
			end else if ((b & utd_pkg::LEAD3_MASK) == utd_pkg::LEAD3_VAL) begin
				conts_left = 2'd2;
				in_astral  = 1'b0;
				unit_bits  = {b[3:0], 12'b0};
			end else if ((b & utd_pkg::LEAD2_MASK) == utd_pkg::LEAD2_VAL) begin
				conts_left = 2'd1;
				in_astral  = 1'b0;
				unit_bits  = {5'b0, b[4:0], 6'b0};
			end else if ((b & utd_pkg::ASCII_MASK) == 8'h00) begin
				have_unit = 1'b1;
				unit      = {8'h00, b};
			end else begin
				// Bad lead: ignore everything up to the end of the string
				string_stopped = 1'b1;
				conts_left     = '0;
				unit_bits      = '0;
				in_astral      = 1'b0;
			end
		end
		if (have_unit || last) begin
			r = '0;
			if (have_unit) begin
				unit_total    = unit_total + 1'b1;
				r.unit_valid  = 1'b1;
				r.first_byte  = order_high_first ? unit[15:8] : unit[7:0];
				r.second_byte = order_high_first ? unit[7:0] : unit[15:8];
			end
			r.done_res   = last;
			r.unit_count = 16'(unit_total);
			r.bad_input  = string_stopped;
			predicted_units.push_back(r);
			if (last)
				clear_string();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		utd_pkg::result_t got;
		utd_pkg::result_t want;
		if (!arst_n) begin
			order_high_first = 1'b0;
			clear_string();
			predicted_units.delete();
			outstanding <= 0;
		end else begin
			// Check the result transaction before predicting from this edge's byte
			if (utf16.valid && utf16.ready) begin
				got.unit_valid  = utf16.unit_valid;
				got.first_byte  = utf16.first_byte;
				got.second_byte = utf16.second_byte;
				got.done_res    = utf16.done_res;
				got.unit_count  = utf16.unit_count;
				got.bad_input   = utf16.bad_input;
				results_seen++;
				if (got.unit_valid === 1'b1)
					units_seen++;
				if (predicted_units.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result uv=%0b b0=%h b1=%h ",
							$time, got.unit_valid, got.first_byte, got.second_byte,
							"done=%0b cnt=%0d bad=%0b",
							got.done_res, got.unit_count, got.bad_input);
				end else begin
					want = predicted_units.pop_front();
					if (got.unit_valid !== want.unit_valid
						|| got.first_byte !== want.first_byte
						|| got.second_byte !== want.second_byte
						|| got.done_res !== want.done_res
						|| got.unit_count !== want.unit_count
						|| got.bad_input !== want.bad_input) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch exp uv=%0b b0=%h b1=%h ",
								$time, want.unit_valid, want.first_byte,
								want.second_byte,
								"done=%0b cnt=%0d bad=%0b | ",
								want.done_res, want.unit_count, want.bad_input,
								"got uv=%0b b0=%h b1=%h ",
								got.unit_valid, got.first_byte, got.second_byte,
								"done=%0b cnt=%0d bad=%0b",
								got.done_res, got.unit_count, got.bad_input);
					end
				end
			end
			if (utf8.valid && utf8.ready)
				decode_byte(utf8.byte_in, utf8.last_byte);
			if (cfg_we)
				order_high_first = cfg_wdata;
			outstanding <= predicted_units.size();
		end
	end

endmodule

FILE: tb/utf8_to_utf16_decoder_tb.sv
// Testbench top: drives UTF-8 strings and byte order settings, then reports the verdict.
`timescale 1ns / 100ps
module utf8_to_utf16_decoder_tb;

	localparam int IDLE_LIMIT = 5000;
	localparam int PHASE_BYTES = 325;

	typedef enum int {STR_CLEAN, STR_NOISE, STR_BROKEN} str_kind_e;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	int send_idle_pct;
	int recv_stall_pct;
	int bytes_sent;
	int strings_sent;
	int mismatches;
	int outstanding;
	int results_seen;
	int units_seen;
	int idle_cycles;

	logic [7:0] str_bytes[$];

	utd_byte_if utf8();
	utd_unit_if utf16();

	utf8_to_utf16_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.utf8      (utf8),
		.utf16     (utf16),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	utd_result_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.utf8         (utf8),
		.utf16        (utf16),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.results_seen (results_seen),
		.units_seen   (units_seen)
	);

	always #5 clk = ~clk;

	initial begin
		utf16.ready = 1'b0;
		forever begin
			@(posedge clk);
			utf16.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Stop the run when no transaction moves for too long
	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((utf8.valid && utf8.ready) || (utf16.valid && utf16.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic [7:0] lead_byte(input int nbytes);
		if (nbytes == 2)
			return 8'hC0 | 8'($urandom_range(0, 31));
		else if (nbytes == 3)
			return 8'hE0 | 8'($urandom_range(0, 15));
		return 8'hF0 | 8'($urandom_range(0, 7));
	endfunction

	function automatic logic [7:0] cont_byte();
		// Mostly proper continuations; now and then any byte at all
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom);
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	function automatic logic [7:0] bad_lead();
		if ($urandom_range(0, 1) == 1)
			return 8'($urandom_range(8'h80, 8'hBF));
		return 8'($urandom_range(8'hF8, 8'hFF));
	endfunction

	task automatic push_char();
		int pick;
		int nbytes;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			str_bytes.push_back(8'($urandom_range(0, 127)));
		end else begin
			nbytes = (pick < 65) ? 2 : (pick < 90) ? 3 : 4;
			str_bytes.push_back(lead_byte(nbytes));
			repeat (nbytes - 1) str_bytes.push_back(cont_byte());
		end
	endtask

	task automatic build_string(input str_kind_e kind);
		int nchars;
		int nbytes;
		str_bytes.delete();
		nchars = $urandom_range(1, 12);
		case (kind)
			STR_CLEAN: begin
				repeat (nchars) push_char();
			end
			STR_NOISE: begin
				repeat (nchars) str_bytes.push_back(8'($urandom));
			end
			default: begin
				repeat ($urandom_range(0, nchars)) push_char();
				if ($urandom_range(0, 1) == 1) begin
					str_bytes.push_back(bad_lead());
					repeat ($urandom_range(0, 6)) push_char();
				end else begin
					// Cut the final sequence short
					nbytes = $urandom_range(2, 4);
					str_bytes.push_back(lead_byte(nbytes));
					repeat ($urandom_range(0, nbytes - 2)) str_bytes.push_back(cont_byte());
				end
			end
		endcase
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			utf8.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		utf8.valid     <= 1'b1;
		utf8.byte_in   <= b;
		utf8.last_byte <= last;
		do @(posedge clk); while (!utf8.ready);
		bytes_sent++;
	endtask

	task automatic send_string();
		for (int i = 0; i < str_bytes.size(); i++)
			send_byte(str_bytes[i], i == str_bytes.size() - 1);
		strings_sent++;
	endtask

	// Hold the sender until every predicted result has been taken
	task automatic drain_results();
		utf8.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_byte_order(input logic high_first);
		cfg_we    <= 1'b1;
		cfg_wdata <= high_first;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input logic high_first);
		int phase_start;
		int pick;
		bit drained;
		set_byte_order(high_first);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		phase_start    = bytes_sent;
		drained        = 1'b0;
		while (bytes_sent - phase_start < PHASE_BYTES) begin
			pick = $urandom_range(0, 99);
			build_string(pick < 70 ? STR_CLEAN : pick < 85 ? STR_NOISE : STR_BROKEN);
			send_string();
			if (!drained && bytes_sent - phase_start >= PHASE_BYTES / 2) begin
				drain_results();
				drained = 1'b1;
			end
		end
		drain_results();
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = 1'b0;
		utf8.valid     = 1'b0;
		utf8.byte_in   = 8'h00;
		utf8.last_byte = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		bytes_sent     = 0;
		strings_sent   = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings at the reset byte order
		str_bytes = '{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC,
			8'hF0, 8'h9F, 8'h98, 8'h80};
		send_string();
		str_bytes = '{8'hC3};
		send_string();
		str_bytes = '{8'h41, 8'h80, 8'h41, 8'hFF};
		send_string();
		str_bytes = '{8'hF8, 8'h41};
		send_string();
		str_bytes = '{8'hDF, 8'hFF};
		send_string();
		str_bytes = '{8'hEF, 8'h00, 8'h7F};
		send_string();
		drain_results();

		run_phase(0, 0, 1'b1);
		run_phase(77, 0, 1'b0);
		run_phase(0, 77, 1'b1);
		run_phase(23, 23, 1'b0);
		repeat (10) @(posedge clk);

		$display("Sent %0d bytes in %0d strings over four idle/stall mixes and both byte orders;",
			bytes_sent, strings_sent);
		$display("checked %0d results, %0d of them code units, %0d failures.",
			results_seen, units_seen, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
